// File: src/ptc_pkg.sv
`default_nettype none
package ptc_pkg;
   localparam int unsigned DivSteps = 32;

   typedef enum logic [1:0] {
      CSR_TEMP_COEFFS       = 2'd0,
      CSR_PRESS_COEFFS_LOW  = 2'd1,
      CSR_PRESS_COEFFS_HIGH = 2'd2,
      CSR_PRESS_COEFF_NINE  = 2'd3
   } csr_index_type;

   // calibration set, widened to 32 bits (t1 and p1 zero extended, the rest sign extended)
   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
   } coeff_type;

   // one divider lane entry
   typedef struct packed {
      logic        valid;
      logic        zero;
      logic        halve;
      logic [31:0] temp;
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] quo;
      logic [32:0] rem;
   } div_lane_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
      asr = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
      mul = 32'(a * b);
   endfunction
endpackage
`default_nettype wire

// File: src/ptc_front.sv
`default_nettype none
// temperature and divisor/numerator stages
module ptc_front import ptc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic [19:0] temp_sample,
   input  wire logic [19:0] pressure_sample,
   input  wire coeff_type   coeff,
   output div_lane_type     out_lane
);
   // stage 1
   logic        s1_valid_ff;
   logic [31:0] s1_ma_ff, s1_dd_ff;
   logic [19:0] s1_rp_ff;
   // stage 2
   logic        s2_valid_ff;
   logic [31:0] s2_fine_ff;
   logic [19:0] s2_rp_ff;
   // stage 3
   logic        s3_valid_ff;
   logic [31:0] s3_temp_ff, s3_a_ff, s3_sq_ff;
   logic [19:0] s3_rp_ff;
   // stage 4
   logic        s4_valid_ff;
   logic [31:0] s4_temp_ff, s4_b6_ff, s4_b5_ff, s4_p3_ff, s4_p2_ff;
   logic [19:0] s4_rp_ff;
   // stage 5
   logic        s5_valid_ff;
   logic [31:0] s5_temp_ff, s5_b_ff, s5_a_ff;
   logic [19:0] s5_rp_ff;
   // stage 6
   logic        s6_valid_ff;
   logic [31:0] s6_temp_ff, s6_den_ff, s6_pm_ff;
   // stage 7
   logic        s7_valid_ff;
   logic [31:0] s7_temp_ff, s7_den_ff, s7_p_ff;

   logic [31:0] rt, d_in, a_in, fine_in, a3_in, q_in, b_in, a5_in, pm_in;

   always_comb begin
      rt      = {12'd0, temp_sample};
      d_in    = (rt >> 4) - coeff.t1;
      fine_in = asr(s1_ma_ff, 5'd11) +
                asr(mul(asr(s1_dd_ff, 5'd12), coeff.t3), 5'd14);
      a3_in   = asr(s2_fine_ff, 5'd1) - 32'd64000;
      q_in    = asr(a3_in, 5'd2);
      b_in    = asr(s4_b6_ff + (s4_b5_ff << 1), 5'd2) + (coeff.p4 << 16);
      a5_in   = asr(asr(s4_p3_ff, 5'd3) + asr(s4_p2_ff, 5'd1), 5'd18);
      pm_in   = (32'd1048576 - {12'd0, s5_rp_ff}) - asr(s5_b_ff, 5'd12);
      a_in    = (rt >> 3) - (coeff.t1 << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
      s1_ma_ff   <= mul(a_in, coeff.t2);
      s1_dd_ff   <= mul(d_in, d_in);
      s1_rp_ff   <= pressure_sample;
      s2_fine_ff <= fine_in;
      s2_rp_ff   <= s1_rp_ff;
      s3_temp_ff <= asr(mul(s2_fine_ff, 32'd5) + 32'd128, 5'd8);
      s3_a_ff    <= a3_in;
      s3_sq_ff   <= mul(q_in, q_in);
      s3_rp_ff   <= s2_rp_ff;
      s4_temp_ff <= s3_temp_ff;
      s4_b6_ff   <= mul(asr(s3_sq_ff, 5'd11), coeff.p6);
      s4_b5_ff   <= mul(s3_a_ff, coeff.p5);
      s4_p3_ff   <= mul(coeff.p3, asr(s3_sq_ff, 5'd13));
      s4_p2_ff   <= mul(coeff.p2, s3_a_ff);
      s4_rp_ff   <= s3_rp_ff;
      s5_temp_ff <= s4_temp_ff;
      s5_b_ff    <= b_in;
      s5_a_ff    <= a5_in;
      s5_rp_ff   <= s4_rp_ff;
      s6_temp_ff <= s5_temp_ff;
      s6_den_ff  <= asr(mul(32'd32768 + s5_a_ff, coeff.p1), 5'd15);
      s6_pm_ff   <= pm_in;
      s7_temp_ff <= s6_temp_ff;
      s7_den_ff  <= s6_den_ff;
      s7_p_ff    <= mul(s6_pm_ff, 32'd3125);
   end

   always_comb begin
      out_lane       = '0;
      out_lane.valid = s7_valid_ff;
      out_lane.zero  = (s7_den_ff == 32'd0);
      out_lane.halve = s7_p_ff[31];
      out_lane.temp  = s7_temp_ff;
      out_lane.den   = s7_den_ff;
      out_lane.num   = s7_p_ff[31] ? s7_p_ff : (s7_p_ff << 1);
      out_lane.quo   = '0;
      out_lane.rem   = '0;
   end
endmodule
`default_nettype wire

// File: src/ptc_divider.sv
`default_nettype none
// restoring divider, one quotient bit per stage
module ptc_divider import ptc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  div_lane_type in_lane,
   output div_lane_type out_lane
);
   div_lane_type lane_ff [DivSteps];
   div_lane_type lane_in [DivSteps];

   always_comb begin
      for (int i = 0; i < DivSteps; i++) begin
         div_lane_type src;
         logic [32:0]  trial;
         src   = (i == 0) ? in_lane : lane_ff[(i == 0) ? 0 : i - 1];
         trial = {src.rem[31:0], src.num[31]};
         lane_in[i] = src;
         lane_in[i].num = src.num << 1;
         if (trial >= {1'b0, src.den}) begin
            lane_in[i].rem = trial - {1'b0, src.den};
            lane_in[i].quo = {src.quo[30:0], 1'b1};
         end else begin
            lane_in[i].rem = trial;
            lane_in[i].quo = {src.quo[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DivSteps; i++) begin
         if (reset) lane_ff[i].valid <= 1'b0;
         else       lane_ff[i].valid <= lane_in[i].valid;
         lane_ff[i].zero  <= lane_in[i].zero;
         lane_ff[i].halve <= lane_in[i].halve;
         lane_ff[i].temp  <= lane_in[i].temp;
         lane_ff[i].num   <= lane_in[i].num;
         lane_ff[i].den   <= lane_in[i].den;
         lane_ff[i].quo   <= lane_in[i].quo;
         lane_ff[i].rem   <= lane_in[i].rem;
      end
   end

   assign out_lane = lane_ff[DivSteps-1];
endmodule
`default_nettype wire

// File: src/ptc_back.sv
`default_nettype none
// final pressure correction
module ptc_back import ptc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  div_lane_type     in_lane,
   input  wire coeff_type   coeff,
   output logic             rsp_valid,
   output logic [31:0]      rsp_temp_centi,
   output logic [31:0]      rsp_pressure_pa,
   output logic             rsp_divisor_zero
);
   logic        t1_valid_ff, t1_zero_ff;
   logic [31:0] t1_temp_ff, t1_p_ff, t1_sq_ff;
   logic        t2_valid_ff, t2_zero_ff;
   logic [31:0] t2_temp_ff, t2_p_ff, t2_a_ff, t2_b_ff;
   logic        out_valid_ff, out_zero_ff;
   logic [31:0] out_temp_ff, out_p_ff;
   logic [31:0] p_in;

   assign p_in = in_lane.halve ? (in_lane.quo << 1) : in_lane.quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         t1_valid_ff  <= in_lane.valid;
         t2_valid_ff  <= t1_valid_ff;
         out_valid_ff <= t2_valid_ff;
      end
      t1_zero_ff  <= in_lane.zero;
      t1_temp_ff  <= in_lane.temp;
      t1_p_ff     <= p_in;
      t1_sq_ff    <= mul(p_in >> 3, p_in >> 3);
      t2_zero_ff  <= t1_zero_ff;
      t2_temp_ff  <= t1_temp_ff;
      t2_p_ff     <= t1_p_ff;
      t2_a_ff     <= mul(coeff.p9, t1_sq_ff >> 13);
      t2_b_ff     <= mul(t1_p_ff >> 2, coeff.p8);
      out_zero_ff <= t2_zero_ff;
      out_temp_ff <= t2_temp_ff;
      out_p_ff    <= t2_zero_ff ? 32'd0 : t2_p_ff +
                     asr(asr(t2_a_ff, 5'd12) + asr(t2_b_ff, 5'd13) + coeff.p7, 5'd4);
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_temp_centi   = out_temp_ff;
   assign rsp_pressure_pa  = out_p_ff;
   assign rsp_divisor_zero = out_zero_ff;
endmodule
`default_nettype wire

// File: src/pressure_temperature_compensation_unit.sv
`default_nettype none
// one transaction accepted every cycle
// the pipeline is 7 front stages, the 32-stage pipelined restoring divider and 3 back stages
// busy is always low; results cannot be stalled
// synchronous reset clears valid bits and all coefficients to zero
module pressure_temperature_compensation_unit import ptc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [19:0]        req_temp_sample,
   input  wire logic [19:0]        req_pressure_sample,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_temp_centi,
   output logic [31:0]             rsp_pressure_pa,
   output logic                    rsp_divisor_zero,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [63:0]        csr_data
);
   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_low_ff, press_high_ff;
   logic [15:0] press_nine_ff;
   coeff_type   coeff;
   div_lane_type front_lane, div_lane;
   logic [31:0] temp_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_low_ff   <= '0;
         press_high_ff  <= '0;
         press_nine_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEMP_COEFFS:       temp_coeffs_ff <= csr_data[47:0];
            CSR_PRESS_COEFFS_LOW:  press_low_ff   <= csr_data;
            CSR_PRESS_COEFFS_HIGH: press_high_ff  <= csr_data;
            CSR_PRESS_COEFF_NINE:  press_nine_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coeff.t1 = {16'd0, temp_coeffs_ff[15:0]};
      coeff.t2 = sx16(temp_coeffs_ff[31:16]);
      coeff.t3 = sx16(temp_coeffs_ff[47:32]);
      coeff.p1 = {16'd0, press_low_ff[15:0]};
      coeff.p2 = sx16(press_low_ff[31:16]);
      coeff.p3 = sx16(press_low_ff[47:32]);
      coeff.p4 = sx16(press_low_ff[63:48]);
      coeff.p5 = sx16(press_high_ff[15:0]);
      coeff.p6 = sx16(press_high_ff[31:16]);
      coeff.p7 = sx16(press_high_ff[47:32]);
      coeff.p8 = sx16(press_high_ff[63:48]);
      coeff.p9 = sx16(press_nine_ff);
   end

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   ptc_front u_front (
      .clock, .reset,
      .in_valid(start), .temp_sample(req_temp_sample),
      .pressure_sample(req_pressure_sample),
      .coeff, .out_lane(front_lane)
   );

   ptc_divider u_div (.clock, .reset, .in_lane(front_lane), .out_lane(div_lane));

   ptc_back u_back (
      .clock, .reset, .in_lane(div_lane), .coeff,
      .rsp_valid, .rsp_temp_centi(temp_bits), .rsp_pressure_pa, .rsp_divisor_zero
   );

   assign rsp_temp_centi = $signed(temp_bits);
endmodule
`default_nettype wire
